FILE: sv/bellman_ford_shortest_path_top_defines.svh
// assertion macros for the shortest path engine
// used by bellman_ford_shortest_path_top only
`ifndef BELLMAN_FORD_SHORTEST_PATH_TOP_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATH_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define BFSP_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BFSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/bfsp_pkg.sv
// shared types and constants of the shortest path engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bfsp_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges = 256;
  localparam int WeightBits = 16;
  localparam int VBits = 6;
  localparam int EBits = 8;
  localparam logic signed [31:0] DistInf = 32'sd999999999;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_SOLVE = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [VBits-1:0] tail;
    logic [VBits-1:0] head;
    logic signed [WeightBits-1:0] wt;
  } edge_t;

  // saturate a 34-bit sum into 32 signed bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    begin
      if (x > 34'sd2147483647) r = 32'sh7fffffff;
      else if (x < -34'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
    end
  endfunction
endpackage
`default_nettype wire

FILE: sv/bellman_ford_shortest_path_top.sv
// shortest path engine: edge table memory, sequencer, result output
// add and clear update the edge count at the next clock; solve makes n passes over
// the edge table, counting the cycle check, each edge a read-modify-write through
// the distance memory
// throughput: one add or clear per cycle while not busy; one solve at a time, busy meanwhile
// results come one per cycle on out_valid; the receiver cannot stall
// reset clears edge count and overflow flag and sets vertex_count to 64; memories unset
`timescale 1ns / 1ps
`default_nettype none
`include "bellman_ford_shortest_path_top_defines.svh"
module bellman_ford_shortest_path_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_kind,
  input  wire logic [5:0] in_from_vertex,
  input  wire logic [5:0] in_to_vertex,
  input  wire logic signed [15:0] in_edge_weight,
  input  wire logic [5:0] in_source_vertex,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [6:0] cfg_data,
  output logic out_valid,
  output logic [5:0] out_vertex,
  output logic signed [31:0] out_distance,
  output logic [5:0] out_predecessor,
  output logic out_has_predecessor,
  output logic out_negative_cycle,
  output logic out_edge_overflow,
  output logic out_last
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_EDGE = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  bfsp_pkg::edge_t edge_mem [bfsp_pkg::MaxEdges];
  bfsp_pkg::edge_t erd_r;
  logic [8:0] total_r;
  logic ovf_r, neg_r, chk_r, evld_r, ph_r;
  logic [6:0] vc_r, n_r, v_r, pass_r;
  logic [8:0] e_r;
  logic [5:0] src_r;
  logic accept;
  logic signed [31:0] rd_dist;
  logic [6:0] rd_pred;
  logic improve;
  logic edge_ok;
  logic rd_vld_r, rd_last_r;
  logic [5:0] rd_v_r;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // edge table: write on add, read one entry in the read phase of each edge step while solving
  always_ff @(posedge clk) begin
    if (accept && in_kind == bfsp_pkg::KIND_ADD && total_r < 9'(bfsp_pkg::MaxEdges))
      edge_mem[total_r[bfsp_pkg::EBits-1:0]] <= '{in_from_vertex, in_to_vertex, in_edge_weight};
    erd_r <= edge_mem[e_r[bfsp_pkg::EBits-1:0]];
  end

  assign edge_ok = evld_r && (7'(erd_r.tail) < n_r) && (7'(erd_r.head) < n_r)
                   && (chk_r || erd_r.head != src_r);

  bfsp_relax u_relax (
    .clk(clk),
    .init_we(state_r == ST_INIT),
    .init_addr(v_r[5:0]),
    .init_dist((v_r[5:0] == src_r) ? 32'sd0 : bfsp_pkg::DistInf),
    .edge_vld(edge_ok),
    .edge_in(erd_r),
    .relax_en(!chk_r),
    .rd_addr(v_r[5:0]),
    .rd_dist(rd_dist),
    .rd_pred(rd_pred),
    .improve(improve)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_kind == bfsp_pkg::KIND_SOLVE) state_nxt = ST_INIT;
      ST_INIT: if (v_r + 7'd1 == n_r) state_nxt = ST_EDGE;
      ST_EDGE: if (ph_r && e_r + 9'd1 >= total_r) state_nxt = ST_WAIT;
               else if (total_r == 9'd0) state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_EDGE;
      ST_OUT:  if (v_r + 7'd1 == n_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    // pass bookkeeping decides wait exits
    if (state_r == ST_WAIT && chk_r) state_nxt = ST_OUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
      ovf_r <= 1'b0;
      vc_r <= 7'd64;
      evld_r <= 1'b0;
      rd_vld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) vc_r <= cfg_data;
      if (accept && in_kind == bfsp_pkg::KIND_ADD) begin
        if (total_r < 9'(bfsp_pkg::MaxEdges)) total_r <= total_r + 9'd1;
        else ovf_r <= 1'b1;
      end
      if (accept && in_kind == bfsp_pkg::KIND_CLEAR) begin
        total_r <= '0;
        ovf_r <= 1'b0;
      end
      // edge read issue: phase 0 reads, phase 1 lets the write settle
      evld_r <= (state_r == ST_EDGE) && !ph_r && (total_r != 9'd0);
      rd_vld_r <= (state_r == ST_OUT);
      out_valid <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      n_r <= (vc_r == 7'd0) ? 7'd1
             : (vc_r > 7'(bfsp_pkg::MaxVertices)) ? 7'(bfsp_pkg::MaxVertices) : vc_r;
      src_r <= in_source_vertex;
      v_r <= '0;
      e_r <= '0;
      ph_r <= 1'b0;
      pass_r <= 7'd1;
      neg_r <= 1'b0;
      chk_r <= 1'b0;
    end
    unique case (state_r)
      ST_INIT: begin
        if (v_r + 7'd1 == n_r) begin
          v_r <= '0;
          chk_r <= (n_r == 7'd1);
        end else begin
          v_r <= v_r + 7'd1;
        end
      end
      ST_EDGE: begin
        ph_r <= !ph_r;
        if (state_nxt == ST_WAIT) e_r <= '0;
        else if (ph_r) e_r <= e_r + 9'd1;
      end
      ST_WAIT: begin
        ph_r <= 1'b0;
        if (!chk_r) begin
          pass_r <= pass_r + 7'd1;
          if (pass_r + 7'd1 >= n_r) chk_r <= 1'b1;
        end
      end
      ST_OUT: v_r <= v_r + 7'd1;
      default: ;
    endcase
    if (chk_r && improve) neg_r <= 1'b1;
    rd_v_r <= v_r[5:0];
    rd_last_r <= (v_r + 7'd1 == n_r);
    out_vertex <= rd_v_r;
    out_distance <= rd_dist;
    out_predecessor <= rd_pred[6] ? rd_pred[5:0] : 6'd0;
    out_has_predecessor <= rd_pred[6];
    out_negative_cycle <= neg_r;
    out_edge_overflow <= ovf_r;
    out_last <= rd_last_r;
  end

  `BFSP_ASSERT_NXT(a_out_burst, out_valid && !out_last, out_valid, "gap inside a result burst")
  `BFSP_ASSERT_NXT(a_last_idle, out_valid && out_last, !out_valid, "result after last")
  `BFSP_ASSERT(a_total_cap, 1'b1, total_r <= 9'(bfsp_pkg::MaxEdges), "edge count beyond table")
endmodule
`default_nettype wire

FILE: sv/bfsp_relax.sv
// relaxation datapath: distance / predecessor memories with read-modify-write
// depends on bfsp_pkg
`timescale 1ns / 1ps
`default_nettype none
module bfsp_relax (
  input  wire logic clk,
  // init write port
  input  wire logic init_we,
  input  wire logic [bfsp_pkg::VBits-1:0] init_addr,
  input  wire logic signed [31:0] init_dist,
  // edge step (edge data valid this cycle)
  input  wire logic edge_vld,
  input  wire bfsp_pkg::edge_t edge_in,
  input  wire logic relax_en,
  // read port for results
  input  wire logic [bfsp_pkg::VBits-1:0] rd_addr,
  output logic signed [31:0] rd_dist,
  output logic [6:0] rd_pred,
  output logic improve
);
  logic signed [31:0] dist_mem [bfsp_pkg::MaxVertices];
  logic [6:0] pred_mem [bfsp_pkg::MaxVertices];
  logic signed [31:0] da_r, db_r;
  bfsp_pkg::edge_t e_r;
  logic s1_r;
  logic signed [33:0] cand;
  logic better;
  logic wr_en;
  logic [bfsp_pkg::VBits-1:0] b_addr;

  // second distance port serves the edge head while an edge is valid, the result read otherwise
  assign b_addr = edge_vld ? edge_in.head : rd_addr;
  assign rd_dist = db_r;

  // stage 1: read both endpoints, stage 2: compare and write back
  always_ff @(posedge clk) begin
    da_r <= dist_mem[edge_in.tail];
    db_r <= dist_mem[b_addr];
    e_r <= edge_in;
    s1_r <= edge_vld;
    rd_pred <= pred_mem[rd_addr];
  end

  // the sequencer lets each edge write back before it issues the next, so no overlap
  assign cand = 34'(da_r) + 34'(e_r.wt);
  assign better = 34'(db_r) > cand;
  assign improve = s1_r && better;
  assign wr_en = improve && relax_en;

  always_ff @(posedge clk) begin
    if (init_we) begin
      dist_mem[init_addr] <= init_dist;
      pred_mem[init_addr] <= 7'd0;
    end else if (wr_en) begin
      dist_mem[e_r.head] <= bfsp_pkg::sat32(cand);
      pred_mem[e_r.head] <= {1'b1, e_r.tail};
    end
  end
endmodule
`default_nettype wire
